@@ design/bdr_pkg.sv @@
// Shared types and constants for the button debounce reporter.
// Holds payload structs, report codes, register indexes and timing constants.
// No dependencies.
package bdr_pkg;

   // Debounce timing and window shape
   localparam logic [31:0] SAMPLE_GAP_MS     = 32'd3;
   localparam logic [3:0]  WINDOW_SAMPLES    = 4'd10;
   localparam logic [3:0]  MATCH_THRESHOLD   = 4'd4;
   localparam logic [31:0] OFFLINE_PERIOD_MS = 32'd1000;

   // Register limits and reset values
   localparam logic [31:0] MIN_PERIOD_MS       = 32'd10;
   localparam logic [31:0] PERIOD_RESET_MS     = 32'd50;
   localparam logic [11:0] LED_BITS            = 12'hfff;
   localparam int          CSR_ADDR_WIDTH      = 4;

   // Report codes
   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_ONLINE  = 2'd1,
      KIND_OFFLINE = 2'd2
   } report_kind_type;

   // Register indexes (word address)
   typedef enum logic [1:0] {
      CSR_REPORT_MODE   = 2'd0,
      CSR_REPORT_PERIOD = 2'd1,
      CSR_LED_ENABLE    = 2'd2
   } csr_index_type;

   // Request payload: one poll
   typedef struct packed {
      logic [31:0] now_ms;
      logic        pin_level;
      logic        online;
   } req_payload_type;

   // Response payload: one result per poll
   typedef struct packed {
      report_kind_type report_kind;
      logic            button_value;
      logic [11:0]     led_drive;
   } rsp_payload_type;

   // Configuration seen by the datapath
   typedef struct packed {
      logic        report_mode;
      logic [31:0] report_period;
      logic [11:0] led_enable;
   } cfg_type;

endpackage

@@ design/bdr_csr.sv @@
// Configuration registers for the button debounce reporter (APB-style port).
// Holds report mode, online report period and LED mask.
// Depends on bdr_pkg.
module bdr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bdr_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready,
   output bdr_pkg::cfg_type                    cfg
);

   logic                 report_mode_ff, report_mode_in;
   logic [31:0]          report_period_ff, report_period_in;
   logic [11:0]          led_enable_ff, led_enable_in;
   logic                 write_en;
   bdr_pkg::csr_index_type index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite;
   assign index      = bdr_pkg::csr_index_type'(csr_paddr[3:2]);

   // Write decode; period saturates at the minimum
   always_comb begin
      report_mode_in   = report_mode_ff;
      report_period_in = report_period_ff;
      led_enable_in    = led_enable_ff;
      if (write_en) begin
         unique case (index)
            bdr_pkg::CSR_REPORT_MODE: begin
               report_mode_in = csr_pwdata[0];
            end
            bdr_pkg::CSR_REPORT_PERIOD: begin
               report_period_in = (csr_pwdata < bdr_pkg::MIN_PERIOD_MS) ?
                                  bdr_pkg::MIN_PERIOD_MS : csr_pwdata;
            end
            bdr_pkg::CSR_LED_ENABLE: begin
               led_enable_in = csr_pwdata[11:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         report_mode_ff   <= 1'b0;
         report_period_ff <= bdr_pkg::PERIOD_RESET_MS;
         led_enable_ff    <= bdr_pkg::LED_BITS;
      end else begin
         report_mode_ff   <= report_mode_in;
         report_period_ff <= report_period_in;
         led_enable_ff    <= led_enable_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (index)
         bdr_pkg::CSR_REPORT_MODE:   csr_prdata = {31'd0, report_mode_ff};
         bdr_pkg::CSR_REPORT_PERIOD: csr_prdata = report_period_ff;
         bdr_pkg::CSR_LED_ENABLE:    csr_prdata = {20'd0, led_enable_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   assign cfg.report_mode   = report_mode_ff;
   assign cfg.report_period = report_period_ff;
   assign cfg.led_enable    = led_enable_ff;

endmodule

@@ design/bdr_debounce.sv @@
// Majority-window debouncer: samples the pin on a time gap, decides per window.
// Outputs the debounced value as it stands after the current poll.
// Depends on bdr_pkg.
module bdr_debounce (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic [31:0] now_ms,
   input  logic        pin_level,
   output logic        debounced_next
);

   logic [31:0] last_sample_ff, last_sample_in;
   logic [3:0]  sample_count_ff, sample_count_in;
   logic [3:0]  match_count_ff, match_count_in;
   logic        window_ref_ff, window_ref_in;
   logic        debounced_ff, debounced_in;
   logic [31:0] elapsed;

   assign elapsed = now_ms - last_sample_ff;

   // Sample step, then window close
   always_comb begin
      last_sample_in  = last_sample_ff;
      sample_count_in = sample_count_ff;
      match_count_in  = match_count_ff;
      window_ref_in   = window_ref_ff;
      debounced_in    = debounced_ff;
      if (elapsed > bdr_pkg::SAMPLE_GAP_MS) begin
         last_sample_in = now_ms;
         if (sample_count_ff == 4'd0) begin
            window_ref_in = pin_level;
         end
         if (pin_level == window_ref_in) begin
            match_count_in = match_count_ff + 4'd1;
         end
         sample_count_in = sample_count_ff + 4'd1;
      end
      if (sample_count_in == bdr_pkg::WINDOW_SAMPLES) begin
         sample_count_in = 4'd0;
         if (match_count_in > bdr_pkg::MATCH_THRESHOLD) begin
            debounced_in = ~window_ref_in;
         end
         match_count_in = 4'd0;
      end
   end

   assign debounced_next = debounced_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sample_ff  <= 32'd0;
         sample_count_ff <= 4'd0;
         match_count_ff  <= 4'd0;
         window_ref_ff   <= 1'b0;
         debounced_ff    <= 1'b0;
      end else if (enable) begin
         last_sample_ff  <= last_sample_in;
         sample_count_ff <= sample_count_in;
         match_count_ff  <= match_count_in;
         window_ref_ff   <= window_ref_in;
         debounced_ff    <= debounced_in;
      end
   end

endmodule

@@ design/bdr_report.sv @@
// Report scheduler: online cycle or change reports, offline fixed-period reports.
// Tracks the last report times and the last reported button value.
// Depends on bdr_pkg.
module bdr_report (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic [31:0]              now_ms,
   input  logic                     online,
   input  logic                     debounced,
   input  bdr_pkg::cfg_type         cfg,
   output bdr_pkg::report_kind_type report_kind
);

   logic        reported_ff, reported_in;
   logic [31:0] online_mark_ff, online_mark_in;
   logic [31:0] offline_mark_ff, offline_mark_in;
   logic [31:0] online_elapsed, offline_elapsed;

   assign online_elapsed  = now_ms - online_mark_ff;
   assign offline_elapsed = now_ms - offline_mark_ff;

   // Decide whether a report is due and move the matching mark
   always_comb begin
      reported_in     = reported_ff;
      online_mark_in  = online_mark_ff;
      offline_mark_in = offline_mark_ff;
      report_kind     = bdr_pkg::KIND_NONE;
      if (online) begin
         if (!cfg.report_mode) begin
            if (online_elapsed > cfg.report_period) begin
               online_mark_in = now_ms;
               report_kind    = bdr_pkg::KIND_ONLINE;
            end
         end else if (debounced != reported_ff) begin
            reported_in = debounced;
            report_kind = bdr_pkg::KIND_ONLINE;
         end
      end else if (offline_elapsed > bdr_pkg::OFFLINE_PERIOD_MS) begin
         offline_mark_in = now_ms;
         report_kind     = bdr_pkg::KIND_OFFLINE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reported_ff     <= 1'b0;
         online_mark_ff  <= 32'd0;
         offline_mark_ff <= 32'd0;
      end else if (enable) begin
         reported_ff     <= reported_in;
         online_mark_ff  <= online_mark_in;
         offline_mark_ff <= offline_mark_in;
      end
   end

endmodule

@@ design/button_debounce_reporter_core.sv @@
// Response: each result is loaded into the response register when its request is taken.
// Throughput: one request per cycle; the response register is refilled in the cycle it
// is emptied, so ready only drops while a held response is stalled.
// Reset: synchronous, active high; clears all debounce and report state, loads
// register defaults (cycle mode, 50 ms period, all LEDs enabled) and empties the response.
module button_debounce_reporter_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bdr_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bdr_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bdr_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   bdr_pkg::cfg_type         cfg;
   bdr_pkg::report_kind_type report_kind;
   bdr_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     req_fire;
   logic                     debounced;

   // Take a request whenever the response register is free or draining
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_fire  = req_valid & req_ready;

   bdr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bdr_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .enable         (req_fire),
      .now_ms         (req_payload.now_ms),
      .pin_level      (req_payload.pin_level),
      .debounced_next (debounced)
   );

   bdr_report u_report (
      .clock       (clock),
      .reset       (reset),
      .enable      (req_fire),
      .now_ms      (req_payload.now_ms),
      .online      (req_payload.online),
      .debounced   (debounced),
      .cfg         (cfg),
      .report_kind (report_kind)
   );

   // Response register
   always_comb begin
      rsp_payload_in.report_kind  = report_kind;
      rsp_payload_in.button_value = debounced;
      rsp_payload_in.led_drive    = ~cfg.led_enable;
      rsp_valid_in                = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

@@ design/bdr_checker.sv @@
// Port-level checker for the button debounce reporter, bound to the top level.
// Depends on bdr_pkg and button_debounce_reporter_core.
module bdr_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input bdr_pkg::req_payload_type req_payload,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input bdr_pkg::rsp_payload_type rsp_payload
);

   // A stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // Every taken request yields a response next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("taken request gave no response");

   // An empty response register never blocks requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty response register");

   // Offline polls never give an online report
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_payload.online |=>
      rsp_payload.report_kind != bdr_pkg::KIND_ONLINE)
      else $error("online report on offline poll");

   // Online polls never give an offline report
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.online |=>
      rsp_payload.report_kind != bdr_pkg::KIND_OFFLINE)
      else $error("offline report on online poll");

endmodule

bind button_debounce_reporter_core bdr_checker u_bdr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
